// ===== design/frtb_pkg.sv =====
// Shared codes and constants for the frame reorder timeout buffer.
`default_nettype none

package frtb_pkg;

  localparam logic MODE_DONE = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam int unsigned IDX_BITS = 32;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned WAIT_BITS = 16;
  localparam int unsigned LIMIT_BITS = 6;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd20;
  localparam logic [WAIT_BITS-1:0] WAIT_SAT = 16'hFFFF;
  localparam logic [IDX_BITS-1:0] DROP_SAT = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== design/frtb_lowest_ready.sv =====
// Finds the lowest set bit of the ready mask above the expected frame.
`default_nettype none

module frtb_lowest_ready #(
  parameter int unsigned WINDOW = 32
) (
  input  wire logic [WINDOW-1:0]         mask,
  output logic                           found,
  output logic [$clog2(WINDOW)-1:0]      index
);

  localparam int unsigned IDX_W = $clog2(WINDOW);

  logic [WINDOW-1:0] upper;
  logic [WINDOW-1:0] lowest;

  always_comb begin
    upper = {mask[WINDOW-1:1], 1'b0};
    lowest = upper & (~upper + WINDOW'(1));
    found = |upper;
    index = '0;
    for (int k = 1; k < WINDOW; k++) begin
      index = index | (lowest[k] ? IDX_W'(k) : IDX_W'(0));
    end
  end

endmodule

`default_nettype wire

// ===== design/frame_reorder_timeout_buffer.sv =====
// Top level of the frame reorder timeout buffer.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   mode, done_index, now_ms
//   out      output     out_valid/out_stall delivered, release_index, dropped_total,
//                                           wait_time, rejected
//   cfg      input      cfg_en              cfg_data (max_wait_ms)
//
// Each request is handled in the cycle it is accepted and its result appears in the
// output register in the next cycle; one request per cycle is sustained unless stalled.
// The rate rests on the combinational update of the ready mask and counters.
// A new request is accepted whenever the output register is empty or being taken.
// Reset empties the window, zeroes the counters and sets the wait limit to 20 ms.
`default_nettype none

module frame_reorder_timeout_buffer #(
  parameter int unsigned WINDOW = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_en,
  input  wire logic [frtb_pkg::LIMIT_BITS-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             mode,
  input  wire logic [frtb_pkg::IDX_BITS-1:0]    done_index,
  input  wire logic [frtb_pkg::TIME_BITS-1:0]   now_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  delivered,
  output logic [frtb_pkg::IDX_BITS-1:0]         release_index,
  output logic [frtb_pkg::IDX_BITS-1:0]         dropped_total,
  output logic [frtb_pkg::WAIT_BITS-1:0]        wait_time,
  output logic                                  rejected
);

  import frtb_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned SH_W = $clog2(WINDOW + 1);

  logic [WINDOW-1:0]     ready_mask;
  logic [IDX_BITS-1:0]   next_expected;
  logic                  waiting;
  logic [TIME_BITS-1:0]  wait_start;
  logic [IDX_BITS-1:0]   drop_counter;
  logic [LIMIT_BITS-1:0] max_wait_ms;

  logic [WINDOW-1:0]     ready_mask_next;
  logic [IDX_BITS-1:0]   next_expected_next;
  logic                  waiting_next;
  logic [TIME_BITS-1:0]  wait_start_next;
  logic [IDX_BITS-1:0]   drop_counter_next;

  logic                  res_delivered;
  logic [IDX_BITS-1:0]   res_index;
  logic [WAIT_BITS-1:0]  res_waited;
  logic                  res_rejected;

  logic                  found;
  logic [IDX_W-1:0]      found_index;
  logic                  accept;

  frtb_lowest_ready #(
    .WINDOW(WINDOW)
  ) u_lowest (
    .mask  (ready_mask),
    .found (found),
    .index (found_index)
  );

  assign in_stall = out_valid & out_stall;
  assign accept = in_valid & ~in_stall;

  always_comb begin
    logic [IDX_BITS-1:0]  offset;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] waited;
    logic [IDX_BITS:0]    drop_sum;
    logic [IDX_BITS-1:0]  drops;
    logic [SH_W-1:0]      shift;

    ready_mask_next = ready_mask;
    next_expected_next = next_expected;
    waiting_next = waiting;
    wait_start_next = wait_start;
    drop_counter_next = drop_counter;
    res_delivered = 1'b0;
    res_index = '0;
    res_waited = '0;
    res_rejected = 1'b0;
    offset = done_index - next_expected;
    start = waiting ? wait_start : now_ms;
    waited = now_ms - start;
    drops = '0;
    shift = '0;
    drop_sum = '0;

    if (mode == MODE_DONE) begin
      if (!offset[IDX_BITS-1]) begin
        if (offset < IDX_BITS'(WINDOW)) begin
          ready_mask_next = ready_mask | (WINDOW'(1) << offset[IDX_W-1:0]);
        end else begin
          res_rejected = 1'b1;
        end
      end
    end else if (ready_mask[0]) begin
      res_delivered = 1'b1;
      res_index = next_expected;
      next_expected_next = next_expected + IDX_BITS'(1);
      ready_mask_next = ready_mask >> 1;
      waiting_next = 1'b0;
      wait_start_next = '0;
    end else begin
      res_waited = (waited > TIME_BITS'(WAIT_SAT)) ? WAIT_SAT : waited[WAIT_BITS-1:0];
      waiting_next = 1'b1;
      wait_start_next = start;
      if (waited >= TIME_BITS'(max_wait_ms)) begin
        if (found) begin
          drops = IDX_BITS'(found_index);
          shift = SH_W'(found_index) + SH_W'(1);
          res_delivered = 1'b1;
          res_index = next_expected + drops;
          res_waited = '0;
          waiting_next = 1'b0;
          wait_start_next = '0;
        end else begin
          drops = IDX_BITS'(1);
          shift = SH_W'(1);
          wait_start_next = now_ms;
        end
        drop_sum = {1'b0, drop_counter} + {1'b0, drops};
        drop_counter_next = drop_sum[IDX_BITS] ? DROP_SAT : drop_sum[IDX_BITS-1:0];
        next_expected_next = next_expected + IDX_BITS'(shift);
        ready_mask_next = ready_mask >> shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait_ms <= LIMIT_RESET;
    end else if (cfg_en) begin
      max_wait_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_mask <= '0;
      next_expected <= '0;
      waiting <= 1'b0;
      wait_start <= '0;
      drop_counter <= '0;
    end else if (accept) begin
      ready_mask <= ready_mask_next;
      next_expected <= next_expected_next;
      waiting <= waiting_next;
      wait_start <= wait_start_next;
      drop_counter <= drop_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      delivered <= res_delivered;
      release_index <= res_index;
      dropped_total <= drop_counter_next;
      wait_time <= res_waited;
      rejected <= res_rejected;
    end
  end

endmodule

`default_nettype wire

// ===== design/frtb_checker.sv =====
// Port-level checks for the frame reorder timeout buffer, bound to the top level.
`default_nettype none

module frtb_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             delivered,
  input wire logic [frtb_pkg::IDX_BITS-1:0]    release_index,
  input wire logic [frtb_pkg::IDX_BITS-1:0]    dropped_total,
  input wire logic [frtb_pkg::WAIT_BITS-1:0]   wait_time,
  input wire logic                             rejected
);

  import frtb_pkg::*;

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted request produced no result.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(release_index)
      && $stable(dropped_total) && $stable(delivered))
    else $error("Stalled result changed.");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !delivered |-> release_index == '0)
    else $error("Frame index set without a release.");

  a_release_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && delivered |-> wait_time == '0 && !rejected)
    else $error("Release reported a wait or a rejection.");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> wait_time == '0 && !delivered)
    else $error("Rejected completion reported a wait or a release.");

endmodule

bind frame_reorder_timeout_buffer frtb_checker u_frtb_checker (.*);

`default_nettype wire

// ===== tb/tb_frame_reorder_timeout_buffer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the frame reorder timeout buffer: directed table, then random.
module tb_frame_reorder_timeout_buffer;
  import frtb_pkg::*;

  localparam int unsigned WIN = 32;
  localparam int unsigned WIN_W = $clog2(WIN);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 84;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ROW_MAX = 32;
  localparam int unsigned PEND_DEPTH = 16;
  localparam int unsigned PEND_W = 4;

  typedef struct packed {
    logic                 delivered;
    logic [IDX_BITS-1:0]  frame;
    logic [IDX_BITS-1:0]  drops;
    logic [WAIT_BITS-1:0] waited;
    logic                 rejected;
  } release_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  m;
    logic [IDX_BITS-1:0]   idx;
    logic [TIME_BITS-1:0]  now;
    logic [LIMIT_BITS-1:0] limit;
    logic                  typed;
    release_t              res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_en = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_data = LIMIT_RESET;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  mode = MODE_DONE;
  logic [IDX_BITS-1:0]   done_index = '0;
  logic [TIME_BITS-1:0]  now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  delivered;
  logic [IDX_BITS-1:0]   release_index;
  logic [IDX_BITS-1:0]   dropped_total;
  logic [WAIT_BITS-1:0]  wait_time;
  logic                  rejected;

  logic [WIN-1:0]        win_ready;
  logic [IDX_BITS-1:0]   win_base;
  logic                  wait_active;
  logic [TIME_BITS-1:0]  wait_begin;
  logic [IDX_BITS-1:0]   drop_count;
  logic [LIMIT_BITS-1:0] wait_limit;

  release_t  pending_results[PEND_DEPTH];
  logic [PEND_W-1:0] pend_head = '0;
  logic [PEND_W-1:0] pend_tail = '0;
  int unsigned pend_count = 0;
  stim_row_t directed_rows[ROW_MAX];
  int unsigned row_count = 0;
  logic      typed_pending = 1'b0;
  release_t  typed_value = '0;
  logic      quiet = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  logic [TIME_BITS-1:0] clock_ms;
  logic [LIMIT_BITS-1:0] phase_limits [PHASES] = '{6'd0, 6'd1, 6'd20, 6'd60, 6'd63, 6'd0};

  frame_reorder_timeout_buffer #(.WINDOW(WIN)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_en(cfg_en),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .done_index(done_index),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .delivered(delivered),
    .release_index(release_index),
    .dropped_total(dropped_total),
    .wait_time(wait_time),
    .rejected(rejected)
  );

  always #10 clk = ~clk;

  function automatic void add_drops(input int unsigned n);
    logic [IDX_BITS:0] sum;
    sum = {1'b0, drop_count} + {1'b0, n};
    drop_count = sum[IDX_BITS] ? DROP_SAT : sum[IDX_BITS-1:0];
  endfunction

  function automatic release_t predict_release(input logic m, input logic [IDX_BITS-1:0] idx,
                                               input logic [TIME_BITS-1:0] now);
    release_t r;
    logic [IDX_BITS-1:0] off;
    logic [TIME_BITS-1:0] waited;
    int unsigned hop;
    r = '0;
    if (m == MODE_DONE) begin
      off = idx - win_base;
      if (!off[IDX_BITS-1]) begin
        if (off < WIN) begin
          win_ready[off[WIN_W-1:0]] = 1'b1;
        end else begin
          r.rejected = 1'b1;
        end
      end
    end else if (win_ready[0]) begin
      r.delivered = 1'b1;
      r.frame = win_base;
    end else begin
      if (!wait_active) begin
        wait_active = 1'b1;
        wait_begin = now;
      end
      waited = now - wait_begin;
      r.waited = (waited > 32'h0000_FFFF) ? WAIT_SAT : waited[WAIT_BITS-1:0];
      if (waited >= TIME_BITS'(wait_limit)) begin
        hop = 0;
        for (int k = WIN - 1; k >= 1; k--) begin
          if (win_ready[k]) hop = k;
        end
        if (hop != 0) begin
          add_drops(hop);
          win_base = win_base + hop;
          win_ready = win_ready >> hop;
          r.delivered = 1'b1;
          r.frame = win_base;
        end else begin
          add_drops(1);
          win_base = win_base + 1;
          win_ready = win_ready >> 1;
          wait_begin = now;
        end
      end
    end
    if (r.delivered) begin
      win_base = win_base + 1;
      win_ready = win_ready >> 1;
      wait_active = 1'b0;
      wait_begin = '0;
      r.waited = '0;
    end
    r.drops = drop_count;
    return r;
  endfunction

  always @(posedge clk) begin
    release_t want;
    release_t got;
    release_t oldest;
    if (rst) begin
      win_ready = '0;
      win_base = '0;
      wait_active = 1'b0;
      wait_begin = '0;
      drop_count = '0;
      wait_limit = LIMIT_RESET;
    end else begin
      if (cfg_en) wait_limit = cfg_data;
      if (in_valid && !in_stall) begin
        want = predict_release(mode, done_index, now_ms);
        if (typed_pending) want = typed_value;
        pending_results[pend_tail] = want;
        pend_tail = pend_tail + 1'b1;
        pend_count++;
      end
      if (out_valid && !out_stall) begin
        got = release_t'{delivered, release_index, dropped_total, wait_time, rejected};
        if (pend_count == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: delivered=%0d frame=%0d drops=%0d waited=%0d rejected=%0d",
                     got.delivered, got.frame, got.drops, got.waited, got.rejected);
          end
        end else begin
          oldest = pending_results[pend_head];
          pend_head = pend_head + 1'b1;
          pend_count--;
          if (got !== oldest) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch expected: delivered=%0d frame=%0d drops=%0d waited=%0d rejected=%0d",
                       oldest.delivered, oldest.frame, oldest.drops, oldest.waited,
                       oldest.rejected);
              $display("         actual:   delivered=%0d frame=%0d drops=%0d waited=%0d rejected=%0d",
                       got.delivered, got.frame, got.drops, got.waited, got.rejected);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void add_req(input logic m, input logic [IDX_BITS-1:0] idx,
                                  input logic [TIME_BITS-1:0] now);
    directed_rows[row_count] = '{ROW_REQ, m, idx, now, '0, 1'b0, '0};
    row_count++;
  endfunction

  function automatic void add_typed(input logic m, input logic [IDX_BITS-1:0] idx,
                                    input logic [TIME_BITS-1:0] now, input logic d,
                                    input logic [IDX_BITS-1:0] f, input logic [IDX_BITS-1:0] dt,
                                    input logic [WAIT_BITS-1:0] w, input logic rj);
    directed_rows[row_count] = '{ROW_REQ, m, idx, now, '0, 1'b1, release_t'{d, f, dt, w, rj}};
    row_count++;
  endfunction

  function automatic void add_cfg(input logic [LIMIT_BITS-1:0] v);
    directed_rows[row_count] = '{ROW_CFG, MODE_DONE, '0, '0, v, 1'b0, '0};
    row_count++;
  endfunction

  task automatic push_request(input logic m, input logic [IDX_BITS-1:0] idx,
                              input logic [TIME_BITS-1:0] now, input logic typed,
                              input release_t res);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    done_index <= idx;
    now_ms <= now;
    typed_pending <= typed;
    typed_value <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
    drain_results();
    cfg_en <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  initial begin
    int r;
    logic [IDX_BITS-1:0] pick_idx;
    logic [TIME_BITS-1:0] pick_now;
    logic pick_mode;

    add_typed(MODE_TAKE, 32'hFFFF_FFFF, 32'd100, 1'b0, 32'd0, 32'd0, 16'd0, 1'b0);
    add_typed(MODE_TAKE, 32'd0, 32'd119, 1'b0, 32'd0, 32'd0, 16'd19, 1'b0);
    add_typed(MODE_TAKE, 32'd0, 32'd120, 1'b0, 32'd0, 32'd1, 16'd20, 1'b0);
    add_typed(MODE_DONE, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    add_typed(MODE_DONE, 32'd33, 32'd0, 1'b0, 32'd0, 32'd1, 16'd0, 1'b1);
    add_typed(MODE_DONE, 32'h8000_0000, 32'd3, 1'b0, 32'd0, 32'd1, 16'd0, 1'b1);
    add_typed(MODE_DONE, 32'h8000_0001, 32'd4, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    add_typed(MODE_DONE, 32'd1, 32'h5555_5555, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    add_typed(MODE_DONE, 32'd1, 32'hAAAA_AAAA, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    add_typed(MODE_TAKE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd1, 32'd1, 16'd0, 1'b0);
    add_typed(MODE_DONE, 32'd33, 32'd0, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    add_typed(MODE_TAKE, 32'd0, 32'hFFFF_FFF0, 1'b0, 32'd0, 32'd1, 16'd0, 1'b0);
    add_typed(MODE_TAKE, 32'd0, 32'd5, 1'b1, 32'd33, 32'd32, 16'd0, 1'b0);
    add_cfg(6'd0);
    add_typed(MODE_TAKE, 32'd0, 32'd7, 1'b0, 32'd0, 32'd33, 16'd0, 1'b0);
    add_cfg(6'd63);
    add_req(MODE_TAKE, 32'hFFFF_FFFF, 32'd1000);
    add_req(MODE_TAKE, 32'd0, 32'd71000);
    add_cfg(6'd60);
    add_req(MODE_DONE, 32'd37, 32'd0);
    add_req(MODE_TAKE, 32'd0, 32'd71001);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < row_count; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_limit(directed_rows[i].limit);
      end else begin
        push_request(directed_rows[i].m, directed_rows[i].idx, directed_rows[i].now,
                     directed_rows[i].typed, directed_rows[i].res);
      end
    end

    phase_limits[PHASES-1] = LIMIT_BITS'($urandom_range(0, 63));
    clock_ms = 32'd5000;
    for (int phase = 0; phase < PHASES; phase++) begin
      write_limit(phase_limits[phase]);
      if (phase == PHASES - 1) quiet = 1'b1;
      if (phase == 2) clock_ms = 32'hFFFF_FFA0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        pick_mode = MODE_DONE;
        pick_now = $urandom;
        if (r < 40) begin
          pick_idx = win_base + $urandom_range(0, WIN - 1);
        end else if (r < 44) begin
          pick_idx = win_base - 1 - $urandom_range(0, 40);
        end else if (r < 48) begin
          pick_idx = win_base + $urandom_range(WIN, 200);
        end else if (r < 50) begin
          pick_idx = $urandom;
        end else begin
          pick_mode = MODE_TAKE;
          pick_idx = $urandom;
          if ($urandom_range(0, 19) == 0) begin
            clock_ms = clock_ms + $urandom_range(0, 70000);
          end else begin
            clock_ms = clock_ms + $urandom_range(0, 12);
          end
          pick_now = clock_ms;
        end
        push_request(pick_mode, pick_idx, pick_now, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
